[src/cau_pkg.sv]
package cau_pkg;

	localparam int DW = 32;
	localparam int PW = 2 * DW;
	localparam int SW = 2 * DW + 1;
	localparam int WW = 2 * DW + 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [DW-1:0] a_re;
		logic signed [DW-1:0] a_im;
		logic signed [DW-1:0] b_re;
		logic signed [DW-1:0] b_im;
	} cmd_t;

	typedef struct packed {
		logic signed [DW-1:0] res_re;
		logic signed [DW-1:0] res_im;
		logic [1:0]           status;
	} result_t;

	// front end output: one signed value per part plus |b|^2
	typedef struct packed {
		logic                 valid;
		logic [1:0]           opcode;
		logic signed [SW-1:0] x_re;
		logic signed [SW-1:0] x_im;
		logic [PW-1:0]        den;
	} front_t;

	typedef struct packed {
		logic [PW-1:0] rem;
		logic [DW-1:0] quo;
		logic [DW-1:0] low;
		logic          neg;
		logic          big;
	} lane_t;

	typedef struct packed {
		logic          valid;
		logic          is_div;
		logic          zero;
		logic [PW-1:0] den;
		result_t       res;
		lane_t         re;
		lane_t         im;
	} chain_t;

	typedef struct packed {
		logic [DW-1:0] val;
		logic          sat;
	} sat_t;

	function automatic sat_t sat_fn(input logic signed [WW-1:0] x);
		sat_t r;
		r.val = x[DW-1:0];
		r.sat = 1'b0;
		if (!((&x[WW-1:DW-1]) || !(|x[WW-1:DW-1]))) begin
			r.sat = 1'b1;
			r.val = x[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[src/cau_front.sv]
module cau_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  cau_pkg::cmd_t  cmd,
	output cau_pkg::front_t out_s2
);

	logic                          valid_s1;
	logic [1:0]                    op_s1;
	logic signed [cau_pkg::DW:0]   as_re_s1, as_im_s1;
	logic signed [cau_pkg::PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;

	logic                          valid_s2;
	logic [1:0]                    op_s2;
	logic signed [cau_pkg::SW-1:0] x_re_s2, x_im_s2;
	logic [cau_pkg::PW-1:0]        den_s2;

	logic signed [cau_pkg::SW-1:0] mre, mim, dre, dim, are, aim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: six exact products, add/sub in parallel
	always_ff @(posedge clk) begin
		op_s1   <= cmd.opcode;
		if (cmd.opcode == cau_pkg::OP_SUB) begin
			as_re_s1 <= (cau_pkg::DW+1)'(cmd.a_re) - (cau_pkg::DW+1)'(cmd.b_re);
			as_im_s1 <= (cau_pkg::DW+1)'(cmd.a_im) - (cau_pkg::DW+1)'(cmd.b_im);
		end else begin
			as_re_s1 <= (cau_pkg::DW+1)'(cmd.a_re) + (cau_pkg::DW+1)'(cmd.b_re);
			as_im_s1 <= (cau_pkg::DW+1)'(cmd.a_im) + (cau_pkg::DW+1)'(cmd.b_im);
		end
		p_rr_s1 <= cmd.a_re * cmd.b_re;
		p_ii_s1 <= cmd.a_im * cmd.b_im;
		p_ri_s1 <= cmd.a_re * cmd.b_im;
		p_ir_s1 <= cmd.a_im * cmd.b_re;
		p_bb_s1 <= cmd.b_re * cmd.b_re;
		p_cc_s1 <= cmd.b_im * cmd.b_im;
	end

	always_comb begin
		mre = cau_pkg::SW'(p_rr_s1) - cau_pkg::SW'(p_ii_s1);
		mim = cau_pkg::SW'(p_ri_s1) + cau_pkg::SW'(p_ir_s1);
		dre = cau_pkg::SW'(p_rr_s1) + cau_pkg::SW'(p_ii_s1);
		dim = cau_pkg::SW'(p_ir_s1) - cau_pkg::SW'(p_ri_s1);
		are = cau_pkg::SW'(as_re_s1);
		aim = cau_pkg::SW'(as_im_s1);
	end

	// stage 2: sums of products or the add/sub result per opcode, and |b|^2
	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		den_s2 <= p_bb_s1 + p_cc_s1;
		case (op_s1)
			cau_pkg::OP_MUL: begin
				x_re_s2 <= mre;
				x_im_s2 <= mim;
			end
			cau_pkg::OP_DIV: begin
				x_re_s2 <= dre;
				x_im_s2 <= dim;
			end
			default: begin
				x_re_s2 <= are;
				x_im_s2 <= aim;
			end
		endcase
	end

	assign out_s2 = '{valid: valid_s2, opcode: op_s2, x_re: x_re_s2, x_im: x_im_s2,
		den: den_s2};

endmodule

[src/cau_div_step.sv]
module cau_div_step (
	input  logic            clk,
	input  logic            arst_n,
	input  cau_pkg::chain_t d,
	output cau_pkg::chain_t q
);

	logic                   valid_q;
	logic                   is_div_q;
	logic                   zero_q;
	logic [cau_pkg::PW-1:0] den_q;
	cau_pkg::result_t       res_q;
	cau_pkg::lane_t         re_q, im_q;

	function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l,
			input logic [cau_pkg::PW-1:0] den);
		cau_pkg::lane_t r;
		logic [cau_pkg::PW:0] t;
		logic                 ge;
		r  = l;
		t  = {l.rem, l.low[cau_pkg::DW-1]};
		ge = t >= {1'b0, den};
		r.rem = ge ? cau_pkg::PW'(t - {1'b0, den}) : t[cau_pkg::PW-1:0];
		r.quo = {l.quo[cau_pkg::DW-2:0], ge};
		r.low = {l.low[cau_pkg::DW-2:0], 1'b0};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	// one restoring quotient bit per lane
	always_ff @(posedge clk) begin
		is_div_q <= d.is_div;
		zero_q   <= d.zero;
		den_q    <= d.den;
		res_q    <= d.res;
		re_q     <= step(d.re, d.den);
		im_q     <= step(d.im, d.den);
	end

	assign q = '{valid: valid_q, is_div: is_div_q, zero: zero_q, den: den_q, res: res_q,
		re: re_q, im: im_q};

endmodule

[src/complex_arith_unit.sv]
// complex add / subtract / multiply / divide on signed fixed point parts
// pipeline: two product stages, two divide setup stages, one stage per quotient bit
// of the restoring divider, one output stage
// throughput: one transaction per cycle, busy is never raised
// the receiver cannot stall: result is valid for exactly the cycle done is high
// reset clears only the valid bits of the pipeline, data registers are not reset
module complex_arith_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cau_pkg::cmd_t    cmd,
	output logic             done,
	output cau_pkg::result_t result
);

	localparam int DW  = cau_pkg::DW;
	localparam int PW  = cau_pkg::PW;
	localparam int SW  = cau_pkg::SW;
	localparam int WW  = cau_pkg::WW;
	localparam int NW  = SW + FRAC_BITS;
	localparam int CW  = 3 * DW + 1;
	localparam int LAT = DW + 5;

	// no backpressure anywhere, every cycle can take a transaction
	assign busy = 1'b0;

	cau_pkg::front_t f_s2;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.cmd    (cmd),
		.out_s2 (f_s2)
	);

	// stage 3: finish add/sub/mul results, take magnitudes for divide
	logic                 valid_s3;
	logic                 is_div_s3;
	logic [PW-1:0]        den_s3;
	cau_pkg::result_t     res_s3;
	logic [SW-1:0]        mag_re_s3, mag_im_s3;
	logic                 neg_re_s3, neg_im_s3;

	logic signed [SW-1:0] al_re, al_im;
	cau_pkg::sat_t        sr, si;

	always_comb begin
		if (f_s2.opcode == cau_pkg::OP_MUL) begin
			// arithmetic shift drops fraction bits, rounding toward minus infinity
			al_re = f_s2.x_re >>> FRAC_BITS;
			al_im = f_s2.x_im >>> FRAC_BITS;
		end else begin
			al_re = f_s2.x_re;
			al_im = f_s2.x_im;
		end
		sr = cau_pkg::sat_fn(WW'(al_re));
		si = cau_pkg::sat_fn(WW'(al_im));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= f_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		is_div_s3        <= (f_s2.opcode == cau_pkg::OP_DIV);
		den_s3           <= f_s2.den;
		res_s3.res_re    <= sr.val;
		res_s3.res_im    <= si.val;
		res_s3.status    <= (sr.sat || si.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		neg_re_s3        <= f_s2.x_re[SW-1];
		neg_im_s3        <= f_s2.x_im[SW-1];
		mag_re_s3        <= f_s2.x_re[SW-1] ? SW'(-f_s2.x_re) : f_s2.x_re;
		mag_im_s3        <= f_s2.x_im[SW-1] ? SW'(-f_s2.x_im) : f_s2.x_im;
	end

	// stage 4: scale numerators, early overflow check, seed the divider
	// a quotient of 2^DW or more always saturates, otherwise DW steps suffice
	logic [NW-1:0]    n_re, n_im;
	logic             valid_s4;
	logic             is_div_s4;
	logic             zero_s4;
	logic [PW-1:0]    den_s4;
	cau_pkg::result_t res_s4;
	cau_pkg::lane_t   re_s4, im_s4;
	cau_pkg::chain_t  c_s4;

	always_comb begin
		n_re = NW'(mag_re_s3) << FRAC_BITS;
		n_im = NW'(mag_im_s3) << FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		is_div_s4  <= is_div_s3;
		zero_s4    <= (den_s3 == '0);
		den_s4     <= den_s3;
		res_s4     <= res_s3;
		re_s4.rem  <= PW'(n_re >> DW);
		re_s4.low  <= n_re[DW-1:0];
		re_s4.quo  <= '0;
		re_s4.neg  <= neg_re_s3;
		re_s4.big  <= CW'(n_re) >= (CW'(den_s3) << DW);
		im_s4.rem  <= PW'(n_im >> DW);
		im_s4.low  <= n_im[DW-1:0];
		im_s4.quo  <= '0;
		im_s4.neg  <= neg_im_s3;
		im_s4.big  <= CW'(n_im) >= (CW'(den_s3) << DW);
	end

	assign c_s4 = '{valid: valid_s4, is_div: is_div_s4, zero: zero_s4, den: den_s4,
		res: res_s4, re: re_s4, im: im_s4};

	// divider chain, one quotient bit per stage
	cau_pkg::chain_t chain [DW+1];

	assign chain[0] = c_s4;

	for (genvar g = 0; g < DW; g++) begin : g_div
		cau_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	// output stage: sign, saturate, status
	function automatic cau_pkg::sat_t div_out(input cau_pkg::lane_t l);
		cau_pkg::sat_t r;
		logic [DW-1:0] half;
		half  = {1'b1, {(DW-1){1'b0}}};
		r.sat = 1'b0;
		r.val = l.neg ? DW'(-l.quo) : l.quo;
		if (l.neg) begin
			if (l.big || l.quo > half) begin
				r.sat = 1'b1;
				r.val = half;
			end
		end else if (l.big || l.quo >= half) begin
			r.sat = 1'b1;
			r.val = ~half;
		end
		return r;
	endfunction

	cau_pkg::chain_t c_end;
	cau_pkg::sat_t   dr, di;

	assign c_end = chain[DW];

	always_comb begin
		dr = div_out(c_end.re);
		di = div_out(c_end.im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= c_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!c_end.is_div) begin
			result <= c_end.res;
		end else if (c_end.zero) begin
			result.res_re <= '0;
			result.res_im <= '0;
			result.status <= cau_pkg::ST_DIVZ;
		end else begin
			result.res_re <= dr.val;
			result.res_im <= di.val;
			result.status <= (dr.sat || di.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	// every accepted transaction comes out on done after passing the whole pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, LAT) |-> (done == $past(start && !busy, LAT)))
		else $error("done does not follow accepted transaction");

	// divide by zero yields a zero result
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == cau_pkg::ST_DIVZ) |-> (result.res_re == '0 && result.res_im == '0))
		else $error("divide by zero result not cleared");

	// reserved status code never leaves the unit
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status != cau_pkg::ST_RSVD))
		else $error("reserved status code");

endmodule

[verif/tb_complex_arith_unit.sv]
module tb_complex_arith_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// scoreboard: predicts each complex result and checks results in order
	class cau_scoreboard;
		cau_pkg::result_t pending_results[$];
		int      mismatch_count;
		int      checked_count;
		int      sat_count;
		int      divz_count;

		// clamp a wide signed value to the 32-bit range, flag when clamped
		function automatic logic [cau_pkg::DW-1:0] clamp_part(input logic signed [199:0] v,
				inout logic clamped);
			logic signed [199:0] hi_lim;
			logic signed [199:0] lo_lim;
			hi_lim = 200'sd2147483647;
			lo_lim = -200'sd2147483648;
			if (v > hi_lim) begin
				clamped = 1'b1;
				return hi_lim[cau_pkg::DW-1:0];
			end
			if (v < lo_lim) begin
				clamped = 1'b1;
				return lo_lim[cau_pkg::DW-1:0];
			end
			return v[cau_pkg::DW-1:0];
		endfunction

		// (num << 16) / den truncated toward zero
		function automatic logic signed [199:0] div_trunc(input logic signed [199:0] num,
				input logic signed [199:0] den);
			logic signed [199:0] mag;
			logic signed [199:0] q;
			mag = (num < 0) ? -num : num;
			q = (mag <<< 16) / den;
			return (num < 0) ? -q : q;
		endfunction

		function automatic cau_pkg::result_t complex_result(input cau_pkg::cmd_t c);
			cau_pkg::result_t r;
			logic signed [199:0] ar, ai, br, bi, xr, xi, den;
			logic clamped;
			ar = c.a_re; ai = c.a_im; br = c.b_re; bi = c.b_im;
			clamped = 1'b0;
			case (cau_pkg::op_t'(c.opcode))
				cau_pkg::OP_ADD: begin xr = ar + br; xi = ai + bi; end
				cau_pkg::OP_SUB: begin xr = ar - br; xi = ai - bi; end
				cau_pkg::OP_MUL: begin
					// arithmetic shift drops low bits: floor
					xr = (ar * br - ai * bi) >>> 16;
					xi = (ar * bi + ai * br) >>> 16;
				end
				default: begin
					if (br == 0 && bi == 0) begin
						r.res_re = '0;
						r.res_im = '0;
						r.status = cau_pkg::ST_DIVZ;
						return r;
					end
					den = br * br + bi * bi;
					xr = div_trunc(ar * br + ai * bi, den);
					xi = div_trunc(ai * br - ar * bi, den);
				end
			endcase
			r.res_re = clamp_part(xr, clamped);
			r.res_im = clamp_part(xi, clamped);
			r.status = clamped ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			return r;
		endfunction

		function void note_command(input cau_pkg::cmd_t c);
			pending_results.push_back(complex_result(c));
		endfunction

		function void check_result(input cau_pkg::result_t got);
			cau_pkg::result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending: re=%h im=%h st=%0d",
					got.res_re, got.res_im, got.status);
				mismatch_count++;
				return;
			end
			want = pending_results.pop_front();
			checked_count++;
			if (want.status == cau_pkg::ST_SAT) sat_count++;
			if (want.status == cau_pkg::ST_DIVZ) divz_count++;
			if (got.res_re !== want.res_re) begin
				$error("res_re expected %h actual %h", want.res_re, got.res_re);
				mismatch_count++;
			end
			if (got.res_im !== want.res_im) begin
				$error("res_im expected %h actual %h", want.res_im, got.res_im);
				mismatch_count++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				mismatch_count++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cau_pkg::cmd_t    cmd;
	logic             done;
	cau_pkg::result_t result;

	cau_scoreboard score;
	int          sent_count;

	complex_arith_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// results cannot be held off, so every done cycle is checked
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			score.check_result(result);
	end

	// random part value, biased toward the edges and small magnitudes
	function automatic logic [cau_pkg::DW-1:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return 32'($signed($urandom_range(0, 8)) - 4);
			4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
			5: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh1fffff);
			default: return $urandom();
		endcase
	endfunction

	// issue one transaction, start stays high until the caller idles
	task automatic send_command(input cau_pkg::cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy === 1'b1)
			@(posedge clk);
		score.note_command(c);
		sent_count++;
	endtask

	// drop start and wait some cycles
	task automatic idle_cycles(input int count);
		start <= 1'b0;
		repeat (count) @(posedge clk);
	endtask

	task automatic send_parts(input cau_pkg::op_t op,
			input logic [cau_pkg::DW-1:0] ar, ai, br, bi);
		cau_pkg::cmd_t c;
		c.opcode = op;
		c.a_re = ar; c.a_im = ai; c.b_re = br; c.b_im = bi;
		send_command(c);
	endtask

	task automatic directed_commands();
		cau_pkg::op_t op;
		// every operation at the range extremes and with one set of ordinary values
		op = op.first();
		do begin
			send_parts(op, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
			send_parts(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
			send_parts(op, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
			send_parts(op, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0000_8000);
			op = op.next();
		end while (op != op.first());
		// zero divisor
		send_parts(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0);
		send_parts(cau_pkg::OP_DIV, '0, '0, '0, '0);
		// smallest divisors, the first of which overflows
		send_parts(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001, '0);
		send_parts(cau_pkg::OP_DIV, 32'hffff_ffff, '0, '0, 32'hffff_ffff);
		// multiply that rounds a negative toward minus infinity
		send_parts(cau_pkg::OP_MUL, 32'hffff_ffff, '0, 32'h0000_0001, '0);
		// divide truncating a negative quotient toward zero
		send_parts(cau_pkg::OP_DIV, 32'hffff_ffff, '0, 32'h0003_0000, '0);
		send_parts(cau_pkg::OP_ADD, '0, '0, '0, '0);
	endtask

	task automatic random_commands(input int count);
		cau_pkg::cmd_t c;
		int   burst;
		int   left;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left) burst = left;
			// start stays high across the burst
			for (int i = 0; i < burst; i++) begin
				c.opcode = 2'($urandom_range(0, 3));
				c.a_re = pick_part();
				c.a_im = pick_part();
				c.b_re = pick_part();
				c.b_im = pick_part();
				send_command(c);
			end
			left -= burst;
			// gap between bursts, sometimes none
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 12));
		end
	endtask

	initial begin
		score = new();
		sent_count = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_commands();
		idle_cycles(3);
		random_commands(1800);
		start <= 1'b0;

		// drain, then allow the pipeline latency to pass
		while (score.pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d transactions, checked %0d results (%0d saturated, %0d divide by zero)",
			sent_count, score.checked_count, score.sat_count, score.divz_count);
		if (score.mismatch_count == 0 && score.pending_results.size() == 0)
			$display("complex_arith_unit regression: pass");
		else
			$display("complex_arith_unit regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("complex_arith_unit regression: fail");
		$finish;
	end

endmodule

[filelist.f]
src/cau_pkg.sv
src/cau_front.sv
src/cau_div_step.sv
src/complex_arith_unit.sv
verif/tb_complex_arith_unit.sv
